// ----- rtl/esv_pkg.sv -----
package esv_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int CSR_ADDR_WIDTH  = 5;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [2:0] REG_CENTER_X    = 3'd0;
   localparam logic [2:0] REG_CENTER_Y    = 3'd1;
   localparam logic [2:0] REG_SEMI_A      = 3'd2;
   localparam logic [2:0] REG_SEMI_B      = 3'd3;
   localparam logic [2:0] REG_ORIENTATION = 3'd4;

   typedef struct packed {
      logic valid;
      logic on_curve;
      logic force_zero;
   } tag_type;

endpackage

// ----- rtl/esv_front.sv -----
module esv_front #(
   parameter int COORD_WIDTH = esv_pkg::COORD_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [COORD_WIDTH-1:0]       x_pos,
   input  logic [COORD_WIDTH-1:0]       center_x,
   input  logic [COORD_WIDTH-1:0]       center_y,
   input  logic [COORD_WIDTH-2:0]       semi_a,
   input  logic [COORD_WIDTH-2:0]       semi_b,
   input  logic                         orientation,
   output esv_pkg::tag_type             out_tag,
   output logic [COORD_WIDTH-1:0]       out_k,
   output logic [4*COORD_WIDTH-5:0]     out_prod,
   output logic [2*COORD_WIDTH-3:0]     out_den
);
   localparam int W = COORD_WIDTH;
   localparam int Q = 2 * (W - 1);

   logic [W:0]   d_in;
   logic [W:0]   ad_in;
   logic [W-2:0] div_in;
   logic [W-2:0] num_in;
   logic         on_in;

   esv_pkg::tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff;
   logic [W-1:0] k1_ff, k2_ff, k3_ff, k4_ff;
   logic [W-2:0] ad1_ff, div1_ff, num1_ff;
   logic [Q-1:0] d2_2_ff, a2_2_ff, n2_2_ff;
   logic [Q-1:0] d2_3_ff, n2_3_ff, diff3_ff;
   logic [Q-1:0] d2_4_ff;
   logic [2*Q-1:0] prod4_ff;

   always_comb begin
      d_in   = {x_pos[W-1], x_pos} - {center_x[W-1], center_x};
      ad_in  = d_in[W] ? (W+1)'(-d_in) : d_in;
      div_in = orientation ? semi_b : semi_a;
      num_in = orientation ? semi_a : semi_b;
      on_in  = ad_in <= {2'b00, div_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
      end else if (en) begin
         tag1_ff <= '{valid: in_valid, on_curve: on_in,
                     force_zero: !on_in || (div_in == '0)};
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k1_ff    <= center_y;
         ad1_ff   <= ad_in[W-2:0];
         div1_ff  <= div_in;
         num1_ff  <= num_in;
         k2_ff    <= k1_ff;
         d2_2_ff  <= Q'(div1_ff) * Q'(div1_ff);
         a2_2_ff  <= Q'(ad1_ff) * Q'(ad1_ff);
         n2_2_ff  <= Q'(num1_ff) * Q'(num1_ff);
         k3_ff    <= k2_ff;
         d2_3_ff  <= d2_2_ff;
         n2_3_ff  <= n2_2_ff;
         diff3_ff <= d2_2_ff - a2_2_ff;
         k4_ff    <= k3_ff;
         d2_4_ff  <= d2_3_ff;
         prod4_ff <= (2*Q)'(n2_3_ff) * (2*Q)'(diff3_ff);
      end
   end

   assign out_tag  = tag4_ff;
   assign out_k    = k4_ff;
   assign out_prod = prod4_ff;
   assign out_den  = d2_4_ff;

endmodule

// ----- rtl/esv_div_pipe.sv -----
module esv_div_pipe #(
   parameter int COORD_WIDTH = esv_pkg::COORD_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  esv_pkg::tag_type             in_tag,
   input  logic [COORD_WIDTH-1:0]       in_k,
   input  logic [4*COORD_WIDTH-5:0]     in_prod,
   input  logic [2*COORD_WIDTH-3:0]     in_den,
   output esv_pkg::tag_type             out_tag,
   output logic [COORD_WIDTH-1:0]       out_k,
   output logic [2*COORD_WIDTH-3:0]     out_quo
);
   localparam int W = COORD_WIDTH;
   localparam int Q = 2 * (W - 1);

   esv_pkg::tag_type tag_ff [Q];
   logic [W-1:0]     k_ff   [Q];
   logic [2*Q-1:0]   acc_ff [Q];
   logic [Q-1:0]     den_ff [Q];

   for (genvar i = 0; i < Q; i++) begin : g_step
      esv_pkg::tag_type tag_src;
      logic [W-1:0]     k_src;
      logic [2*Q-1:0]   acc_src;
      logic [Q-1:0]     den_src;
      logic [Q:0]       shifted;
      logic             ge;
      logic [Q:0]       rem_new;

      if (i == 0) begin : g_first
         assign tag_src = in_tag;
         assign k_src   = in_k;
         assign acc_src = in_prod;
         assign den_src = in_den;
      end else begin : g_next
         assign tag_src = tag_ff[i-1];
         assign k_src   = k_ff[i-1];
         assign acc_src = acc_ff[i-1];
         assign den_src = den_ff[i-1];
      end

      always_comb begin
         shifted = {acc_src[2*Q-1:Q], acc_src[Q-1]};
         ge      = shifted >= {1'b0, den_src};
         rem_new = ge ? (shifted - {1'b0, den_src}) : shifted;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[i] <= '0;
         end else if (en) begin
            tag_ff[i] <= tag_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            k_ff[i]   <= k_src;
            den_ff[i] <= den_src;
            acc_ff[i] <= {rem_new[Q-1:0], acc_src[Q-2:0], ge};
         end
      end
   end

   assign out_tag = tag_ff[Q-1];
   assign out_k   = k_ff[Q-1];
   assign out_quo = acc_ff[Q-1][Q-1:0];

endmodule

// ----- rtl/esv_sqrt_pipe.sv -----
module esv_sqrt_pipe #(
   parameter int COORD_WIDTH = esv_pkg::COORD_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  esv_pkg::tag_type             in_tag,
   input  logic [COORD_WIDTH-1:0]       in_k,
   input  logic [2*COORD_WIDTH-3:0]     in_value,
   output esv_pkg::tag_type             out_tag,
   output logic [COORD_WIDTH-1:0]       out_k,
   output logic [COORD_WIDTH-2:0]       out_root
);
   localparam int W = COORD_WIDTH;
   localparam int Q = 2 * (W - 1);
   localparam int S = W - 1;

   esv_pkg::tag_type tag_ff  [S];
   logic [W-1:0]     k_ff    [S];
   logic [Q-1:0]     val_ff  [S];
   logic [W:0]       rem_ff  [S];
   logic [W-2:0]     root_ff [S];

   for (genvar i = 0; i < S; i++) begin : g_step
      esv_pkg::tag_type tag_src;
      logic [W-1:0]     k_src;
      logic [Q-1:0]     val_src;
      logic [W:0]       rem_src;
      logic [W-2:0]     root_src;
      logic [W+1:0]     r4;
      logic [W+1:0]     trial;
      logic             ge;
      logic [W+1:0]     rem_new;

      if (i == 0) begin : g_first
         assign tag_src  = in_tag;
         assign k_src    = in_k;
         assign val_src  = in_value;
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : g_next
         assign tag_src  = tag_ff[i-1];
         assign k_src    = k_ff[i-1];
         assign val_src  = val_ff[i-1];
         assign rem_src  = rem_ff[i-1];
         assign root_src = root_ff[i-1];
      end

      always_comb begin
         r4      = {rem_src[W-1:0], val_src[Q-1:Q-2]};
         trial   = {1'b0, root_src, 2'b01};
         ge      = r4 >= trial;
         rem_new = ge ? (r4 - trial) : r4;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[i] <= '0;
         end else if (en) begin
            tag_ff[i] <= tag_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            k_ff[i]    <= k_src;
            val_ff[i]  <= {val_src[Q-3:0], 2'b00};
            rem_ff[i]  <= rem_new[W:0];
            root_ff[i] <= {root_src[W-3:0], ge};
         end
      end
   end

   assign out_tag  = tag_ff[S-1];
   assign out_k    = k_ff[S-1];
   assign out_root = root_ff[S-1];

endmodule

// ----- rtl/ellipse_span_evaluator_top.sv -----
// Ellipse span evaluator.
// Request channel: req_valid / req_stall carry one x sample (req_x_pos) per
// request. Result channel: rsp_valid / rsp_stall return y_upper, y_lower and
// on_curve for that sample, one result per request, in request order.
// Center, semi-axes and orientation are set through the APB-style register
// port (psel, penable, pwrite, paddr, pwdata, prdata, pready); the user must
// write them only while idle, which the block itself does not enforce. The
// pipeline has four front stages (offset, squares, difference, product), one
// stage per quotient bit of the divider and one stage per root bit of the
// square root, then the saturating output register. Throughput is one
// request per cycle while the receiver does not stall.
// Reset clears all valid bits and loads the register defaults (center 0,
// both semi-axes 16, horizontal orientation).
// A stall from the receiver while a result is held freezes the whole
// pipeline and raises req_stall in the same cycle; nothing is lost or
// repeated, and bubbles in the pipeline do not stall the request side.
module ellipse_span_evaluator_top #(
   parameter int COORD_WIDTH = esv_pkg::COORD_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [COORD_WIDTH-1:0]              req_x_pos,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [COORD_WIDTH-1:0]              rsp_y_upper,
   output logic [COORD_WIDTH-1:0]              rsp_y_lower,
   output logic                                rsp_on_curve,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [esv_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [esv_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [esv_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                pready
);
   localparam int W  = COORD_WIDTH;
   localparam int Q  = 2 * (W - 1);
   localparam int DW = esv_pkg::CSR_DATA_WIDTH;

   logic [W-1:0] center_x_ff, center_y_ff;
   logic [W-2:0] semi_a_ff, semi_b_ff;
   logic         orient_ff;
   logic [2:0]   reg_index;
   logic         en;

   esv_pkg::tag_type front_tag, div_tag, sqrt_tag;
   logic [W-1:0]   front_k, div_k, sqrt_k;
   logic [2*Q-1:0] front_prod;
   logic [Q-1:0]   front_den, div_quo;
   logic [W-2:0]   sqrt_root;

   logic [W-2:0] off;
   logic [W:0]   up_sum, lo_sum;
   logic [W-1:0] up_sat, lo_sat;
   logic [W-1:0] smax, smin;

   logic         rsp_valid_ff;
   logic [W-1:0] y_upper_ff, y_lower_ff;
   logic         on_curve_ff;

   assign reg_index = paddr[4:2];
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         semi_a_ff   <= (W-1)'(16);
         semi_b_ff   <= (W-1)'(16);
         orient_ff   <= 1'b0;
      end else if (psel && penable && pwrite) begin
         case (reg_index)
            esv_pkg::REG_CENTER_X:    center_x_ff <= pwdata[W-1:0];
            esv_pkg::REG_CENTER_Y:    center_y_ff <= pwdata[W-1:0];
            esv_pkg::REG_SEMI_A:      semi_a_ff   <= pwdata[W-2:0];
            esv_pkg::REG_SEMI_B:      semi_b_ff   <= pwdata[W-2:0];
            esv_pkg::REG_ORIENTATION: orient_ff   <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         esv_pkg::REG_CENTER_X:    prdata = DW'(center_x_ff);
         esv_pkg::REG_CENTER_Y:    prdata = DW'(center_y_ff);
         esv_pkg::REG_SEMI_A:      prdata = DW'(semi_a_ff);
         esv_pkg::REG_SEMI_B:      prdata = DW'(semi_b_ff);
         esv_pkg::REG_ORIENTATION: prdata = DW'(orient_ff);
         default:                  prdata = '0;
      endcase
   end

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   esv_front #(.COORD_WIDTH(W)) u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_valid),
      .x_pos       (req_x_pos),
      .center_x    (center_x_ff),
      .center_y    (center_y_ff),
      .semi_a      (semi_a_ff),
      .semi_b      (semi_b_ff),
      .orientation (orient_ff),
      .out_tag     (front_tag),
      .out_k       (front_k),
      .out_prod    (front_prod),
      .out_den     (front_den)
   );

   esv_div_pipe #(.COORD_WIDTH(W)) u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_tag  (front_tag),
      .in_k    (front_k),
      .in_prod (front_prod),
      .in_den  (front_den),
      .out_tag (div_tag),
      .out_k   (div_k),
      .out_quo (div_quo)
   );

   esv_sqrt_pipe #(.COORD_WIDTH(W)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_tag   (div_tag),
      .in_k     (div_k),
      .in_value (div_quo),
      .out_tag  (sqrt_tag),
      .out_k    (sqrt_k),
      .out_root (sqrt_root)
   );

   always_comb begin
      smax   = {1'b0, {(W-1){1'b1}}};
      smin   = {1'b1, {(W-1){1'b0}}};
      off    = sqrt_tag.force_zero ? '0 : sqrt_root;
      up_sum = {sqrt_k[W-1], sqrt_k} + {2'b00, off};
      lo_sum = {sqrt_k[W-1], sqrt_k} - {2'b00, off};
      up_sat = (up_sum[W] != up_sum[W-1]) ? smax : up_sum[W-1:0];
      lo_sat = (lo_sum[W] != lo_sum[W-1]) ? smin : lo_sum[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= sqrt_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_upper_ff  <= up_sat;
         y_lower_ff  <= lo_sat;
         on_curve_ff <= sqrt_tag.on_curve;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_y_upper  = y_upper_ff;
   assign rsp_y_lower  = y_lower_ff;
   assign rsp_on_curve = on_curve_ff;

`ifndef SYNTHESIS
   a_off_curve_flat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_on_curve |-> rsp_y_upper == rsp_y_lower)
      else $error("off-curve result with nonzero span");
   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $signed(rsp_y_upper) >= $signed(rsp_y_lower))
      else $error("upper y below lower y");
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule
